// ----- hw/rtl/strict_priority_message_queue_top_assert.svh -----
// assertion macros for the queue checker
`ifndef STRICT_PRIORITY_MESSAGE_QUEUE_TOP_ASSERT_SVH
`define STRICT_PRIORITY_MESSAGE_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SPMQ_ASSERT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SPMQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/spmq_pkg.sv -----
// types and constants of the strict priority message queue
package spmq_pkg;

  localparam int QueueDepthDef     = 16;
  localparam int PriorityLevelsDef = 4;
  localparam int PriW              = 2;
  localparam int TdataW            = 48;
  localparam int InTuserW          = 1;
  localparam int OutTuserW         = 2;

  typedef enum logic [0:0] {
    REQ_ENQUEUE = 1'b0,
    REQ_DEQUEUE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_BAD_PRI = 2'd2,
    STATUS_EMPTY   = 2'd3
  } status_e;

  // first member sits in the highest bits
  typedef struct packed {
    logic [15:0] payload_handle;
    logic [11:0] time_stamp;
    logic [5:0]  src_device;
    logic [5:0]  dest_device;
    logic [2:0]  category;
  } entry_t;

  typedef struct packed {
    status_e           status;
    logic [PriW-1:0]   pri;
    entry_t            entry;
  } result_t;

endpackage

// ----- hw/rtl/strict_priority_message_queue_top.sv -----
// strict priority message queue: one circular fifo per priority level
//
// Usage: the slave stream carries requests, the master stream one result per
// request, in request order. tuser on the slave side selects enqueue (0) or
// dequeue (1); tdata carries the descriptor. An enqueue stores the descriptor
// in the fifo of its priority, or drops it with status full or bad priority.
// A dequeue returns the oldest descriptor of the highest non-empty priority
// (level 0 first), or status empty with zero data.
// An accepted transaction's result is registered before the master side; one
// transaction per cycle is taken while s_axis_tready is high, set by the single
// write and single registered read port of the descriptor memory.
// A skid register behind the result register lets one more transaction in
// while the receiver stalls; with both full, s_axis_tready drops until the
// receiver takes a result.
// Reset empties all fifos (pointers and fill counts to zero) and clears both
// result slots; descriptor memory is not cleared and needs no sweep.
module strict_priority_message_queue_top
  import spmq_pkg::*;
#(
  parameter int QUEUE_DEPTH     = QueueDepthDef,
  parameter int PRIORITY_LEVELS = PriorityLevelsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // priority_req, category, dest_device, src_device, time_stamp, payload_handle
  input  logic [TdataW-1:0]    s_axis_tdata,
  // req_type
  input  logic [InTuserW-1:0]  s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_priority, out_category, out_dest_device, out_src_device,
  // out_time_stamp, out_payload_handle
  output logic [TdataW-1:0]    m_axis_tdata,
  // status
  output logic [OutTuserW-1:0] m_axis_tuser
);

  localparam int PtrW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam int LvlW     = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int MemDepth = PRIORITY_LEVELS * QUEUE_DEPTH;
  localparam int AddrW    = $clog2(MemDepth);

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    n = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
    return n;
  endfunction

  logic [PtrW-1:0] head_q [PRIORITY_LEVELS];
  logic [PtrW-1:0] tail_q [PRIORITY_LEVELS];
  logic [CntW-1:0] cnt_q  [PRIORITY_LEVELS];

  entry_t          mem_q [MemDepth];
  entry_t          rd_q;

  logic            st1_valid_q;
  status_e         st1_status_q;
  logic [LvlW-1:0] st1_lvl_q;
  logic            st1_sel_q;
  logic            skid_valid_q;
  result_t         skid_q;
  result_t         st1_res;
  result_t         out_res;

  logic            in_acc;
  logic            out_fire;
  req_e            req;
  logic [PriW-1:0] pri_req;
  logic [LvlW-1:0] enq_lvl;
  entry_t          in_entry;
  logic            bad_pri;
  logic            full;
  logic            enq_ok;
  logic            deq_hit;
  logic [LvlW-1:0] deq_lvl;
  logic            deq_go;
  status_e         status_d;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;

  assign req      = req_e'(s_axis_tuser[0]);
  assign pri_req  = s_axis_tdata[PriW-1:0];
  assign in_entry = entry_t'(s_axis_tdata[PriW+$bits(entry_t)-1:PriW]);
  assign enq_lvl  = pri_req[LvlW-1:0];

  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = skid_valid_q || st1_valid_q;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  assign bad_pri = ({1'b0, pri_req} >= (PriW + 1)'(PRIORITY_LEVELS));
  assign full    = !bad_pri && (cnt_q[enq_lvl] == CntW'(QUEUE_DEPTH));
  assign enq_ok  = (req == REQ_ENQUEUE) && !bad_pri && !full;
  assign deq_go  = (req == REQ_DEQUEUE) && deq_hit;

  // lowest-numbered non-empty level wins
  always_comb begin
    deq_hit = 1'b0;
    deq_lvl = '0;
    for (int l = PRIORITY_LEVELS - 1; l >= 0; l--) begin
      if (cnt_q[l] != '0) begin
        deq_hit = 1'b1;
        deq_lvl = LvlW'(l);
      end
    end
  end

  always_comb begin
    status_d = STATUS_OK;
    if (req == REQ_ENQUEUE) begin
      if (bad_pri) begin
        status_d = STATUS_BAD_PRI;
      end else if (full) begin
        status_d = STATUS_FULL;
      end
    end else if (!deq_hit) begin
      status_d = STATUS_EMPTY;
    end
  end

  assign wr_addr = AddrW'(enq_lvl) * AddrW'(QUEUE_DEPTH) + AddrW'(tail_q[enq_lvl]);
  assign rd_addr = AddrW'(deq_lvl) * AddrW'(QUEUE_DEPTH) + AddrW'(head_q[deq_lvl]);

  // descriptor memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && enq_ok) begin
      mem_q[wr_addr] <= in_entry;
    end
    if (in_acc && deq_go) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else if (in_acc) begin
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        if (enq_ok && (enq_lvl == LvlW'(l))) begin
          tail_q[l] <= next_ptr(tail_q[l]);
          cnt_q[l]  <= cnt_q[l] + CntW'(1);
        end
        if (deq_go && (deq_lvl == LvlW'(l))) begin
          head_q[l] <= next_ptr(head_q[l]);
          cnt_q[l]  <= cnt_q[l] - CntW'(1);
        end
      end
    end
  end

  always_comb begin
    st1_res.status = st1_status_q;
    st1_res.pri    = st1_sel_q ? PriW'(st1_lvl_q) : '0;
    st1_res.entry  = st1_sel_q ? rd_q : '0;
  end

  assign out_res      = skid_valid_q ? skid_q : st1_res;
  assign m_axis_tdata = {(TdataW - $bits(entry_t) - PriW)'(0), out_res.entry, out_res.pri};
  assign m_axis_tuser = out_res.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_acc) begin
        st1_valid_q <= 1'b1;
        if (st1_valid_q && !out_fire) begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        st1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      st1_status_q <= status_d;
      st1_lvl_q    <= deq_lvl;
      st1_sel_q    <= deq_go;
      if (st1_valid_q && !out_fire) begin
        skid_q <= st1_res;
      end
    end
  end

endmodule

// ----- hw/rtl/spmq_checker.sv -----
// port-level checks of the strict priority message queue, bound to the top
`include "strict_priority_message_queue_top_assert.svh"

module spmq_checker
  import spmq_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [TdataW-1:0]    s_axis_tdata,
  input logic [InTuserW-1:0]  s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [TdataW-1:0]    m_axis_tdata,
  input logic [OutTuserW-1:0] m_axis_tuser
);

  `SPMQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  `SPMQ_ASSERT(a_zero_data_unless_ok, m_axis_tvalid && (m_axis_tuser != STATUS_OK), m_axis_tdata == '0, "non-ok result carries data")

  `SPMQ_ASSERT_NEXT(a_accept_gives_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted transaction gave no result")

  `SPMQ_ASSERT(a_backpressure_has_backlog, !s_axis_tready, m_axis_tvalid, "input stalled with no result pending")

endmodule

bind strict_priority_message_queue_top spmq_checker u_spmq_checker (.*);

// ----- bench/testbench.sv -----
// self-checking testbench for the strict priority message queue
module testbench;
  import spmq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDepth     = QueueDepthDef;
  localparam int LevelCount = PriorityLevelsDef;
  localparam int TotalItems = 1400;
  localparam int EntryW     = $bits(entry_t);

  class priority_queue_scoreboard;
    entry_t      slot_mem[LevelCount][QDepth];
    int unsigned rd_idx[LevelCount];
    int unsigned wr_idx[LevelCount];
    int unsigned fill[LevelCount];
    result_t     expected_results[$];
    int          errors;

    function int pending();
      return expected_results.size();
    endfunction

    // works out the result of one accepted transaction
    function void note_request(req_e kind, logic [TdataW-1:0] data);
      result_t         res;
      logic [PriW-1:0] lvl;
      bit              found;
      int              p;
      res   = '0;
      lvl   = data[PriW-1:0];
      found = 1'b0;
      if (kind == REQ_ENQUEUE) begin
        if (lvl >= LevelCount) begin
          res.status = STATUS_BAD_PRI;
        end else if (fill[lvl] >= QDepth) begin
          res.status = STATUS_FULL;
        end else begin
          slot_mem[lvl][wr_idx[lvl]] = data[PriW +: EntryW];
          wr_idx[lvl] = (wr_idx[lvl] + 1) % QDepth;
          fill[lvl]++;
          res.status = STATUS_OK;
        end
      end else begin
        res.status = STATUS_EMPTY;
        for (p = 0; p < LevelCount; p++) begin
          if (!found && fill[p] != 0) begin
            found       = 1'b1;
            res.status  = STATUS_OK;
            res.pri     = p[PriW-1:0];
            res.entry   = slot_mem[p][rd_idx[p]];
            rd_idx[p]   = (rd_idx[p] + 1) % QDepth;
            fill[p]--;
          end
        end
      end
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [OutTuserW-1:0] user, logic [TdataW-1:0] data);
      result_t want;
      entry_t  got;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual status %0h data %h",
                 $time, user, data);
        return;
      end
      want = expected_results.pop_front();
      got  = data[PriW +: EntryW];
      compare_field("status", want.status, user);
      compare_field("priority", want.pri, data[PriW-1:0]);
      compare_field("category", want.entry.category, got.category);
      compare_field("dest_device", want.entry.dest_device, got.dest_device);
      compare_field("src_device", want.entry.src_device, got.src_device);
      compare_field("time_stamp", want.entry.time_stamp, got.time_stamp);
      compare_field("payload_handle", want.entry.payload_handle, got.payload_handle);
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TdataW-1:0]    s_axis_tdata  = '0;
  logic [InTuserW-1:0]  s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TdataW-1:0]    m_axis_tdata;
  logic [OutTuserW-1:0] m_axis_tuser;

  priority_queue_scoreboard sb = new();

  int sent_count    = 0;
  int tx_gap_max    = 12;
  int rx_stall_max  = 12;
  int rx_hold_count = 0;

  strict_priority_message_queue_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // result checked before the new request is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tuser, m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(req_e'(s_axis_tuser), s_axis_tdata);
      end
    end
  end

  function automatic entry_t rand_entry();
    logic [63:0] r;
    case ($urandom_range(0, 7))
      0: r = '0;
      1: r = '1;
      default: r = {$urandom, $urandom};
    endcase
    return r[EntryW-1:0];
  endfunction

  task automatic send_request(input req_e kind, input logic [PriW-1:0] lvl,
                              input entry_t ent);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(TdataW - EntryW - PriW){1'b0}}, ent, lvl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // receiver with random stalls and an occasional long hold-off
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_count > 0) begin
        gap           = rx_hold_count;
        rx_hold_count = 0;
      end else begin
        gap = $urandom_range(0, rx_stall_max);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int               mode;
    int               len;
    int               enq_weight;
    logic [PriW-1:0]  lvl;
    bit               hold_done;
    bit               pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty dequeue, level order, extremes, full level
    send_request(REQ_DEQUEUE, 2'd0, '0);
    send_request(REQ_ENQUEUE, 2'd3, '1);
    send_request(REQ_ENQUEUE, 2'd0, '0);
    send_request(REQ_ENQUEUE, 2'd2, rand_entry());
    send_request(REQ_ENQUEUE, 2'd1, rand_entry());
    repeat (5) send_request(REQ_DEQUEUE, 2'd3, '1);
    repeat (QDepth + 1) send_request(REQ_ENQUEUE, 2'd1, rand_entry());

    while (sent_count < TotalItems) begin
      mode         = $urandom_range(0, 9);
      tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 12;
      rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      if (mode < 2) begin
        // overfill one level
        lvl = PriW'($urandom_range(0, LevelCount - 1));
        len = QDepth + $urandom_range(1, 3);
        repeat (len) send_request(REQ_ENQUEUE, lvl, rand_entry());
      end else if (mode < 4) begin
        len = $urandom_range(1, LevelCount * QDepth + 2);
        repeat (len) send_request(REQ_DEQUEUE, PriW'($urandom_range(0, 3)), rand_entry());
      end else begin
        enq_weight = $urandom_range(2, 8);
        len        = $urandom_range(8, 40);
        repeat (len) begin
          send_request(($urandom_range(0, 9) < enq_weight) ? REQ_ENQUEUE : REQ_DEQUEUE,
                       PriW'($urandom_range(0, 3)), rand_entry());
        end
      end
      if (!hold_done && sent_count > 400) begin
        hold_done     = 1'b1;
        rx_hold_count = 200;
        tx_gap_max    = 1;
        repeat (30) send_request(REQ_ENQUEUE, PriW'($urandom_range(0, 3)), rand_entry());
      end
      if (!pause_done && sent_count > 800) begin
        pause_done = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- strict_priority_message_queue_top.f -----
+incdir+hw/rtl
hw/rtl/spmq_pkg.sv
hw/rtl/strict_priority_message_queue_top.sv
hw/rtl/spmq_checker.sv
bench/testbench.sv
